### rtl/kscl_pkg.sv
// shared types, constants and helpers for the keypad scanner code lock
// no dependencies; imported by every module of the block
package kscl_pkg;

    localparam int TIMER_W      = 16;
    localparam int CODE_W       = 44;
    localparam int CODE_FIELDS  = CODE_W / 4;
    localparam int DIGIT_W      = 4;
    localparam int COUNT_OUT_W  = 4;
    localparam int KEYS         = 16;
    localparam int ROW_W        = 2;
    localparam int COLS         = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = CODE_W;
    localparam int IN_DATA_W    = 8;
    localparam int OUT_DATA_W   = 32;
    localparam int DEF_CODE_DIGITS = 11;

    localparam logic [TIMER_W-1:0] TIMER_MAX         = '1;
    localparam logic [TIMER_W-1:0] SCAN_PERIOD_RESET = 16'd50;
    localparam logic [TIMER_W-1:0] KEY_GAP_RESET     = 16'd300;
    localparam logic [CODE_W-1:0]  CODE_VALUE_RESET  = 44'h410_0050_4326;

    // register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_GAP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_VALUE  = 2'd2;

    // key positions with a function other than a digit
    localparam logic [3:0] KEY_CLEAR = 4'd3;
    localparam logic [3:0] KEY_ENTER = 4'd15;

    typedef struct packed {
        logic              is_digit;
        logic [DIGIT_W-1:0] digit;
    } key_info_t;

    // scanner state after the current beat
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [KEYS-1:0]  keys;
    } scan_t;

    // lock state after the current beat
    typedef struct packed {
        logic               unlocked;
        logic [COUNT_OUT_W-1:0] count;
        logic [DIGIT_W-1:0] last_digit;
    } lock_t;

    function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] t);
        logic [TIMER_W-1:0] r;
        r = (t == TIMER_MAX) ? TIMER_MAX : t + 1'b1;
        return r;
    endfunction

    // keypad layout: 7 8 9 C / 4 5 6 - / 1 2 3 - / 0 - - E
    function automatic key_info_t key_decode(input logic [3:0] k);
        key_info_t r;
        r.is_digit = 1'b1;
        case (k)
            4'd0:    r.digit = 4'd7;
            4'd1:    r.digit = 4'd8;
            4'd2:    r.digit = 4'd9;
            4'd4:    r.digit = 4'd4;
            4'd5:    r.digit = 4'd5;
            4'd6:    r.digit = 4'd6;
            4'd8:    r.digit = 4'd1;
            4'd9:    r.digit = 4'd2;
            4'd10:   r.digit = 4'd3;
            4'd12:   r.digit = 4'd0;
            default:
            begin
                r.is_digit = 1'b0;
                r.digit    = 4'd0;
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/kscl_scan.sv
// row scanner: scan timer, row drive and the pressed-key map
// depends on kscl_pkg
module kscl_scan (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [kscl_pkg::TIMER_W-1:0]   scan_period,
    input  logic [kscl_pkg::COLS-1:0]      cols,
    output kscl_pkg::scan_t                scan_next
);
    import kscl_pkg::*;

    logic [TIMER_W-1:0] timer_reg, timer_next, timer_inc;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [KEYS-1:0]    keys_reg, keys_next;

    always_comb
    begin
        timer_inc  = sat_inc(timer_reg);
        timer_next = timer_inc;
        row_next   = row_reg;
        keys_next  = keys_reg;
        if (timer_inc >= scan_period)
        begin
            // low column level means pressed
            keys_next[row_reg*COLS +: COLS] = ~cols;
            timer_next = '0;
            row_next   = row_reg + 1'b1;
        end
        scan_next.row  = row_next;
        scan_next.keys = keys_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= '0;
            row_reg   <= '0;
            keys_reg  <= '0;
        end
        else if (step)
        begin
            timer_reg <= timer_next;
            row_reg   <= row_next;
            keys_reg  <= keys_next;
        end
    end

endmodule

### rtl/kscl_lock.sv
// key action and code lock: gap timer, digit buffer, compare and lock flag
// depends on kscl_pkg
module kscl_lock #(
    parameter int CODE_DIGITS = kscl_pkg::DEF_CODE_DIGITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [kscl_pkg::TIMER_W-1:0]   key_gap,
    input  logic [kscl_pkg::CODE_W-1:0]    code_value,
    input  logic [kscl_pkg::KEYS-1:0]      keys,
    output kscl_pkg::lock_t                lock_next
);
    import kscl_pkg::*;

    localparam int CNT_W = $clog2(CODE_DIGITS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_DIGITS);

    logic [TIMER_W-1:0] gap_reg, gap_next, gap_inc;
    logic [DIGIT_W-1:0] store_reg [CODE_DIGITS];
    logic [DIGIT_W-1:0] store_next [CODE_DIGITS];
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               open_reg, open_next;
    logic [DIGIT_W-1:0] recent_reg, recent_next;

    logic [3:0]         key_pos;
    logic               single;
    key_info_t          info;
    logic               match;
    logic [63:0]        code_ext;

    always_comb
    begin
        // position of the single pressed key
        key_pos = '0;
        for (int i = 0; i < KEYS; i++)
        begin
            if (keys[i])
                key_pos = 4'(i);
        end
        single = (keys != '0) && ((keys & (keys - 1'b1)) == '0);
        info   = key_decode(key_pos);

        // buffer against code, unentered digits hold zero
        code_ext = 64'(code_value);
        match    = 1'b1;
        for (int i = 0; i < CODE_DIGITS; i++)
        begin
            if (i < CODE_FIELDS)
            begin
                if (store_reg[i] != code_ext[4*i +: 4])
                    match = 1'b0;
            end
            else if (store_reg[i] != '0)
                match = 1'b0;
        end

        gap_inc     = sat_inc(gap_reg);
        gap_next    = gap_inc;
        store_next  = store_reg;
        count_next  = count_reg;
        open_next   = open_reg;
        recent_next = recent_reg;

        if (gap_inc >= key_gap && single)
        begin
            if (info.is_digit)
            begin
                if (count_reg < CNT_FULL)
                begin
                    for (int i = 0; i < CODE_DIGITS; i++)
                    begin
                        if (count_reg == CNT_W'(i))
                            store_next[i] = info.digit;
                    end
                    count_next = count_reg + 1'b1;
                end
                recent_next = info.digit;
                open_next   = 1'b0;
                gap_next    = '0;
            end
            else if (key_pos == KEY_CLEAR || key_pos == KEY_ENTER)
            begin
                open_next = (key_pos == KEY_ENTER) ? match : 1'b0;
                for (int i = 0; i < CODE_DIGITS; i++)
                    store_next[i] = '0;
                count_next  = '0;
                recent_next = '0;
                gap_next    = '0;
            end
        end

        lock_next.unlocked   = open_next;
        lock_next.count      = COUNT_OUT_W'(count_next);
        lock_next.last_digit = recent_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg    <= '0;
            count_reg  <= '0;
            open_reg   <= 1'b0;
            recent_reg <= '0;
            for (int i = 0; i < CODE_DIGITS; i++)
                store_reg[i] <= '0;
        end
        else if (step)
        begin
            gap_reg    <= gap_next;
            count_reg  <= count_next;
            open_reg   <= open_next;
            recent_reg <= recent_next;
            store_reg  <= store_next;
        end
    end

endmodule

### rtl/keypad_scan_code_lock.sv
// top level of the keypad scanner code lock: stream ports, config registers,
// input and result registers; depends on kscl_pkg, kscl_scan, kscl_lock
//
// usage
//   s_axis carries one beat per 1 ms tick: the column levels of the row that
//   is driven low (bit low = key pressed). m_axis returns exactly one result
//   beat per input beat, in order: the row to drive next, the lock flag, the
//   digit count, the full 16-bit key map and the last digit entered.
//   cfg_we/cfg_index/cfg_data write scan_period (0), key_gap (1) and
//   code_value (2); other indexes are ignored. write config only while
//   the block is idle.
// timing
//   a beat is captured in the input register, processed once the output
//   register is free, and its result then sits in the output register.
//   throughput is one beat per cycle while m_axis is not stalled; the limit
//   is the single state update per cycle of the scan and gap counters.
// reset and stall
//   rst_n clears all timers, the key map, the digit buffer and the lock flag
//   and loads the config defaults (50, 300, the factory code). when m_axis is
//   stalled, the held result waits in the output register, one more beat
//   waits in the input register, and s_axis_tready then drops.
module keypad_scan_code_lock #(
    parameter int CODE_DIGITS = kscl_pkg::DEF_CODE_DIGITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input beats
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [kscl_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [3:0] column_levels
    // result beats
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [1:0] row_select, [2] unlocked, [6:3] digits_entered,
    // [22:7] key_map, [26:23] last_digit
    output logic [kscl_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // config write port
    input  logic                             cfg_we,
    input  logic [kscl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kscl_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import kscl_pkg::*;

    logic [TIMER_W-1:0] scan_period_reg;
    logic [TIMER_W-1:0] key_gap_reg;
    logic [CODE_W-1:0]  code_value_reg;

    logic               in_valid_reg;
    logic [COLS-1:0]    cols_reg;
    logic               out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic               out_free;
    logic               step;
    scan_t              scan_next;
    lock_t              lock_next;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_period_reg <= SCAN_PERIOD_RESET;
            key_gap_reg     <= KEY_GAP_RESET;
            code_value_reg  <= CODE_VALUE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCAN_PERIOD: scan_period_reg <= cfg_data[TIMER_W-1:0];
                CFG_KEY_GAP:     key_gap_reg     <= cfg_data[TIMER_W-1:0];
                CFG_CODE_VALUE:  code_value_reg  <= cfg_data[CODE_W-1:0];
                default:         ;
            endcase
        end
    end

    // result register free, or emptied this cycle
    assign out_free      = !out_valid_reg || m_axis_tready;
    // held beat moves through the state update into the result register
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            cols_reg <= s_axis_tdata[COLS-1:0];
    end

    kscl_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .scan_period (scan_period_reg),
        .cols        (cols_reg),
        .scan_next   (scan_next)
    );

    kscl_lock #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_lock (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .key_gap    (key_gap_reg),
        .code_value (code_value_reg),
        .keys       (scan_next.keys),
        .lock_next  (lock_next)
    );

    // pack the result beat, row_select lowest and last_digit highest
    assign out_data_next = OUT_DATA_W'({lock_next.last_digit, scan_next.keys,
                                        lock_next.count, lock_next.unlocked,
                                        scan_next.row});

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= step;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### sim/keypad_scan_code_lock_check.sv
`timescale 1ns / 1ps
// result checker for the keypad scanner code lock: predicts one result beat
// per input beat and compares it with m_axis; depends on kscl_pkg
module keypad_scan_code_lock_check (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [kscl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [kscl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [kscl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kscl_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              errors,
    output int                              pending
);
    import kscl_pkg::*;

    localparam int ENTRY_LEN  = DEF_CODE_DIGITS;

    // digit behind each key position, -1 for clear, enter and unused keys
    localparam int KEYPAD_DIGIT [KEYS] = '{7, 8, 9, -1, 4, 5, 6, -1,
                                            1, 2, 3, -1, 0, -1, -1, -1};

    // result beat, first field in the top bits
    typedef struct packed {
        logic [4:0]             pad;
        logic [DIGIT_W-1:0]     last_digit;
        logic [KEYS-1:0]        key_map;
        logic [COUNT_OUT_W-1:0] count;
        logic                   unlocked;
        logic [ROW_W-1:0]       row;
    } lock_view_t;

    logic [TIMER_W-1:0] scan_period;
    logic [TIMER_W-1:0] key_gap;
    logic [CODE_W-1:0]  code_value;
    logic [TIMER_W-1:0] scan_ticks;
    logic [TIMER_W-1:0] gap_ticks;
    logic [ROW_W-1:0]   scan_row;
    logic [KEYS-1:0]    pressed;
    logic [DIGIT_W-1:0] entry [ENTRY_LEN];
    int                 entry_count;
    logic               lock_open;
    logic [DIGIT_W-1:0] recent;
    lock_view_t         view_queue [$];
    lock_view_t         want;
    lock_view_t         got;
    int                 fail_count = 0;

    function automatic void clear_entry();
        foreach (entry[i])
            entry[i] = '0;
        entry_count = 0;
        recent      = '0;
    endfunction

    // all buffer slots against the code digits, empty slots hold zero
    function automatic logic code_accepted();
        for (int i = 0; i < ENTRY_LEN; i++)
            if (entry[i] != code_value[4*i +: 4])
                return 1'b0;
        return 1'b1;
    endfunction

    // one 1 ms tick: row sample, then at most one key action
    function automatic lock_view_t tick_lock(input logic [COLS-1:0] cols);
        lock_view_t v;
        int         k;
        scan_ticks = (scan_ticks == TIMER_MAX) ? scan_ticks : scan_ticks + 1'b1;
        gap_ticks  = (gap_ticks == TIMER_MAX) ? gap_ticks : gap_ticks + 1'b1;
        if (scan_ticks >= scan_period)
        begin
            for (int c = 0; c < COLS; c++)
                pressed[scan_row * 4 + c] = !cols[c];
            scan_ticks = '0;
            scan_row   = scan_row + 1'b1;
        end
        k = 0;
        while (k < KEYS - 1 && !pressed[k])
            k++;
        // only a lone key acts, and only once the gap has run out
        if (gap_ticks >= key_gap && pressed != '0 && (pressed & (pressed - 1'b1)) == '0)
        begin
            if (KEYPAD_DIGIT[k] >= 0)
            begin
                // a full buffer keeps its digits but the key still counts
                if (entry_count < ENTRY_LEN)
                begin
                    entry[entry_count] = DIGIT_W'(KEYPAD_DIGIT[k]);
                    entry_count++;
                end
                recent    = DIGIT_W'(KEYPAD_DIGIT[k]);
                lock_open = 1'b0;
                gap_ticks = '0;
            end
            else if (k == int'(KEY_CLEAR))
            begin
                lock_open = 1'b0;
                clear_entry();
                gap_ticks = '0;
            end
            else if (k == int'(KEY_ENTER))
            begin
                lock_open = code_accepted();
                clear_entry();
                gap_ticks = '0;
            end
        end
        v.pad        = '0;
        v.last_digit = recent;
        v.key_map    = pressed;
        v.count      = COUNT_OUT_W'(entry_count);
        v.unlocked   = lock_open;
        v.row        = scan_row;
        return v;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            fail_count++;
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_period = SCAN_PERIOD_RESET;
            key_gap     = KEY_GAP_RESET;
            code_value  = CODE_VALUE_RESET;
            scan_ticks  = '0;
            gap_ticks   = '0;
            scan_row    = '0;
            pressed     = '0;
            lock_open   = 1'b0;
            clear_entry();
            view_queue.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SCAN_PERIOD: scan_period = cfg_data[TIMER_W-1:0];
                    CFG_KEY_GAP:     key_gap     = cfg_data[TIMER_W-1:0];
                    CFG_CODE_VALUE:  code_value  = cfg_data[CODE_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (view_queue.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result beat expected none, got %0h", $time,
                             m_axis_tdata);
                end
                else
                begin
                    want = view_queue.pop_front();
                    got  = m_axis_tdata;
                    check_field("row_select", 32'(want.row), 32'(got.row));
                    check_field("unlocked", 32'(want.unlocked), 32'(got.unlocked));
                    check_field("digits_entered", 32'(want.count), 32'(got.count));
                    check_field("key_map", 32'(want.key_map), 32'(got.key_map));
                    check_field("last_digit", 32'(want.last_digit),
                                32'(got.last_digit));
                    check_field("tdata pad", 32'(want.pad), 32'(got.pad));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                view_queue.push_back(tick_lock(s_axis_tdata[COLS-1:0]));
            errors  <= fail_count;
            pending <= view_queue.size();
        end
    end

endmodule

### sim/keypad_scan_code_lock_test.sv
`timescale 1ns / 1ps
// top of the keypad scanner code lock testbench: emulates the key matrix on
// the driven row and gives the verdict; depends on kscl_pkg, the block, the checker
module keypad_scan_code_lock_test;
    import kscl_pkg::*;

    localparam int RANDOM_BEATS = 1700;
    localparam int SHORT_PHASE  = 40;
    localparam int TIMEOUT_NS   = 2_000_000;
    localparam int DRAIN_CYCLES = 8;

    // key positions without a function
    localparam int UNUSED_KEY [4] = '{7, 11, 13, 14};
    // key position of each digit 0..9
    localparam int DIGIT_KEY [10] = '{12, 8, 9, 10, 4, 5, 6, 0, 1, 2};

    // opening beats with scan_period 0 and key_gap 0: every beat samples the
    // next row and a lone key acts on every beat; code is all zeros
    localparam logic [3:0] OPENING_LEVELS [28] = '{
        4'hE, 4'hF, 4'hF, 4'h7,  // digit 7 three times, then 7 with enter held
        4'hF, 4'h7, 4'hF, 4'hE,  // enter alone on a wrong code, then unused-key chords
        4'hF, 4'hF, 4'hF, 4'h7,  // digit 0 twice, then enter alone opens the lock
        4'h7, 4'hF, 4'hF, 4'hF,  // clear with enter does nothing, clear alone relocks
        4'hF, 4'hF, 4'h0, 4'hF,  // a whole row pressed at once
        4'hF, 4'hF, 4'hB, 4'hD,  // digit 3 alone, then with an unused key
        4'hF, 4'hF, 4'hF, 4'hB   // unused keys alone do nothing
    };

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index     = '0;
    logic [CFG_DATA_W-1:0]   cfg_data      = '0;

    int                      error_count;
    int                      pending_beats;

    // idle chances in percent, changed as the run goes on
    int                      tx_idle_pct  = 9;
    int                      rx_stall_pct = 64;
    int                      beats_sent   = 0;
    int                      phase_no     = 0;

    // row the block drives next, followed from the beats sent so far
    logic [TIMER_W-1:0]      trk_period = SCAN_PERIOD_RESET;
    logic [TIMER_W-1:0]      trk_ticks  = '0;
    logic [ROW_W-1:0]        trk_row    = '0;

    // keys held down on the emulated matrix
    logic [KEYS-1:0]         held = '0;
    int                      hold_len = 8;
    int                      rel_len  = 8;

    logic [3:0]              code_digit [DEF_CODE_DIGITS];
    logic [CODE_W-1:0]       code_word = '0;

    always #1 clk = ~clk;

    keypad_scan_code_lock uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    keypad_scan_code_lock_check lock_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (error_count),
        .pending       (pending_beats)
    );

    // result side stalls at random according to the current mode
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);

    // column levels the matrix shows for the row about to be sampled
    function automatic logic [COLS-1:0] row_levels();
        return ~held[{trk_row, 2'b00} +: COLS];
    endfunction

    // one tick beat, each cycle in front of it idle at the current chance
    task automatic push_tick(input logic [COLS-1:0] levels);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= IN_DATA_W'(levels);
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        // same scan timing as the block, so the right row sees the keys
        trk_ticks = (trk_ticks == TIMER_MAX) ? trk_ticks : trk_ticks + 1'b1;
        if (trk_ticks >= trk_period)
        begin
            trk_ticks = '0;
            trk_row   = trk_row + 1'b1;
        end
        beats_sent++;
    endtask

    // hold a set of keys, then release them
    task automatic press_keys(input logic [KEYS-1:0] keys);
        held = keys;
        repeat (hold_len) push_tick(row_levels());
        held = '0;
        repeat (rel_len) push_tick(row_levels());
    endtask

    // stop sending and wait until every result beat has come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [TIMER_W-1:0] period, input logic [TIMER_W-1:0] gap,
                              input logic [CODE_W-1:0] code);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SCAN_PERIOD;
        cfg_data  <= CFG_DATA_W'(period);
        @(posedge clk);
        cfg_index <= CFG_KEY_GAP;
        cfg_data  <= CFG_DATA_W'(gap);
        @(posedge clk);
        cfg_index <= CFG_CODE_VALUE;
        cfg_data  <= CFG_DATA_W'(code);
        @(posedge clk);
        cfg_we    <= 1'b0;
        trk_period = period;
    endtask

    // random code, often with trailing zeros so short entries can match
    task automatic pick_code();
        int cut;
        cut = $urandom_range(0, DEF_CODE_DIGITS);
        foreach (code_digit[i])
        begin
            code_digit[i]     = (i < cut) ? 4'($urandom_range(0, 9)) : 4'd0;
            code_word[4*i +: 4] = code_digit[i];
        end
    endtask

    // timing that lets each press act exactly once, sometimes a short gap
    // so that held keys repeat
    task automatic configure_normal();
        int          period;
        int          gap;
        period   = ($urandom_range(0, 3) == 0) ? 2 : 1;
        hold_len = 8 * period;
        rel_len  = 8 * period;
        gap      = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 12 * period;
        pick_code();
        set_config(TIMER_W'(period), TIMER_W'(gap), code_word);
    endtask

    // one keyed sequence: mostly well-formed code entries, some broken ones
    task automatic run_entry();
        int kind;
        int n;
        int slip;
        int seq [$];
        kind = $urandom_range(0, 5);
        case (kind)
            0:
            begin
                // the right code, then enter
                foreach (code_digit[i])
                    seq.push_back(DIGIT_KEY[code_digit[i]]);
                seq.push_back(int'(KEY_ENTER));
            end
            1:
            begin
                // one digit off
                slip = $urandom_range(0, DEF_CODE_DIGITS - 1);
                foreach (code_digit[i])
                    seq.push_back(DIGIT_KEY[(i == slip) ?
                        (code_digit[i] + $urandom_range(1, 9)) % 10 : code_digit[i]]);
                seq.push_back(int'(KEY_ENTER));
            end
            2:
            begin
                // short, partial or overlong entry, running into a full buffer
                n = $urandom_range(0, DEF_CODE_DIGITS + 2);
                for (int i = 0; i < n; i++)
                    seq.push_back((i < DEF_CODE_DIGITS && $urandom_range(0, 1)) ?
                        DIGIT_KEY[code_digit[i]] : DIGIT_KEY[$urandom_range(0, 9)]);
                seq.push_back(int'(KEY_ENTER));
            end
            3:
            begin
                // junk digits wiped by clear, then the right code
                repeat ($urandom_range(1, 5)) seq.push_back(DIGIT_KEY[$urandom_range(0, 9)]);
                seq.push_back(int'(KEY_CLEAR));
                foreach (code_digit[i])
                    seq.push_back(DIGIT_KEY[code_digit[i]]);
                seq.push_back(int'(KEY_ENTER));
            end
            4:
            begin
                // code mixed with unused keys, which must change nothing
                foreach (code_digit[i])
                begin
                    if ($urandom_range(0, 3) == 0)
                        seq.push_back(UNUSED_KEY[$urandom_range(0, 3)]);
                    seq.push_back(DIGIT_KEY[code_digit[i]]);
                end
                seq.push_back(int'(KEY_ENTER));
            end
            default:
            begin
                // chords and bouncing column levels
                repeat (3) press_keys((KEYS'(1) << $urandom_range(0, KEYS - 1)) |
                                      (KEYS'(1) << $urandom_range(0, KEYS - 1)));
                repeat (SHORT_PHASE / 2) push_tick(COLS'($urandom_range(0, 15)));
            end
        endcase
        foreach (seq[i])
            press_keys(KEYS'(1) << seq[i]);
    endtask

    initial
    begin
        foreach (code_digit[i])
            code_digit[i] = 4'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // zero periods: sample and act on every beat
        set_config('0, '0, '0);
        foreach (OPENING_LEVELS[i])
            push_tick(OPENING_LEVELS[i]);

        while (beats_sent < RANDOM_BEATS)
        begin
            // slow receiver first, then slow sender, then full rate
            if (beats_sent < RANDOM_BEATS / 3)
            begin
                tx_idle_pct  = 9;
                rx_stall_pct = 64;
            end
            else if (beats_sent < 2 * RANDOM_BEATS / 3)
            begin
                tx_idle_pct  = 64;
                rx_stall_pct = 9;
            end
            else
            begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            if (phase_no % 3 == 0)
            begin
                case ((phase_no / 3) % 4)
                    1:
                    begin
                        // largest periods and a code no key can reach
                        set_config(TIMER_MAX, TIMER_MAX, '1);
                        repeat (SHORT_PHASE) push_tick(COLS'($urandom_range(0, 15)));
                        configure_normal();
                    end
                    3:
                    begin
                        // periods of 1, held keys repeat on every tick
                        foreach (code_digit[i])
                            code_digit[i] = 4'd0;
                        hold_len = 4;
                        rel_len  = 4;
                        set_config(TIMER_W'(1), TIMER_W'(1), '0);
                    end
                    default: configure_normal();
                endcase
            end
            run_entry();
            phase_no++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("keypad_scan_code_lock_test: clean");
        else
            $display("keypad_scan_code_lock_test: errors");
        $finish;
    end

    // hang guard
    initial
    begin
        #(TIMEOUT_NS);
        $display("keypad_scan_code_lock_test: errors");
        $finish;
    end

endmodule

### filelist.f
rtl/kscl_pkg.sv
rtl/kscl_scan.sv
rtl/kscl_lock.sv
rtl/keypad_scan_code_lock.sv
sim/keypad_scan_code_lock_check.sv
sim/keypad_scan_code_lock_test.sv
